// File: design/serial_memory_monitor_assert.svh
// Assertion macros used by the serial memory monitor output queue (smm_outq).
`ifndef SERIAL_MEMORY_MONITOR_ASSERT_SVH
`define SERIAL_MEMORY_MONITOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/smm_pkg.sv
`default_nettype none

package smm_pkg;

  localparam logic [7:0] OP_PING     = 8'h18;
  localparam logic [7:0] OP_READ     = 8'h20;
  localparam logic [7:0] OP_READV    = 8'h21;
  localparam logic [7:0] OP_WRITEV   = 8'h22;
  localparam logic [7:0] OP_EXEC     = 8'h23;
  localparam logic [7:0] OP_WRITE    = 8'h00;
  localparam logic [7:0] CMD_HI_MASK = 8'hf0;

  localparam logic [7:0] ST_OK  = 8'h01;
  localparam logic [7:0] ST_UNK = 8'h04;

  localparam logic IN_SERIAL = 1'b0;
  localparam logic IN_RDATA  = 1'b1;

  localparam int MAX_RES = 5;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ARGS_B,
    PH_CK_R,
    PH_RD_WAIT,
    PH_WR_DATA,
    PH_CK_W,
    PH_ARGS_V,
    PH_V_WAIT,
    PH_V_DATA,
    PH_ARGS_X
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TX,
    KIND_RD,
    KIND_WR,
    KIND_JMP
  } out_kind_t;

  typedef struct packed {
    out_kind_t   kind;
    logic [7:0]  tx;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [2:0]  size;
  } result_t;

  // All results caused by one input word, in delivery order from entry 0.
  typedef struct packed {
    logic [2:0]                 cnt;
    result_t [MAX_RES-1:0]      res;
  } bundle_t;

  function automatic result_t mk_tx(input logic [7:0] b);
    result_t r;
    r       = '0;
    r.kind  = KIND_TX;
    r.tx    = b;
    return r;
  endfunction

  function automatic result_t mk_bus(input out_kind_t k, input logic [31:0] a,
                                     input logic [31:0] d, input logic [2:0] s);
    result_t r;
    r       = '0;
    r.kind  = k;
    r.addr  = a;
    r.wdata = d;
    r.size  = s;
    return r;
  endfunction

  // Accumulate one byte of a native-order field.
  function automatic logic [31:0] native_acc(input logic nbe, input logic [31:0] acc,
                                             input logic [7:0] b, input logic [1:0] idx);
    logic [31:0] r;
    if (nbe) begin
      r = {acc[23:0], b};
    end else begin
      r = acc | ({24'h0, b} << {idx, 3'b000});
    end
    return r;
  endfunction

  function automatic logic size_ok(input logic [7:0] s);
    return (s == 8'd1) || (s == 8'd2) || (s == 8'd4);
  endfunction

  function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] idx);
    logic [31:0] t;
    t = w >> {idx, 3'b000};
    return t[7:0];
  endfunction

endpackage

`default_nettype wire

// File: design/smm_core.sv
`default_nettype none

module smm_core
  import smm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic        cfg_wdata,
  input  wire logic        fire,
  input  wire logic        in_kind,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [31:0] read_data,
  output bundle_t          bundle
);

  logic        nbe;
  phase_t      phase, phase_next;
  logic [7:0]  command, command_next;
  logic [31:0] address, address_next;
  logic [15:0] length, length_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [7:0]  access_size, access_size_next;
  logic [31:0] value, value_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      nbe <= 1'b0;
    end else if (cfg_wen) begin
      nbe <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      command     <= '0;
      address     <= '0;
      length      <= '0;
      byte_count  <= '0;
      access_size <= '0;
      value       <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      command     <= command_next;
      address     <= address_next;
      length      <= length_next;
      byte_count  <= byte_count_next;
      access_size <= access_size_next;
      value       <= value_next;
    end
  end

  always_comb begin
    logic [2:0]  sz;
    logic [7:0]  ack_ok;
    logic [31:0] addr_inc;
    logic [15:0] len_dec;
    logic [15:0] len_sh;
    logic [31:0] acc_addr;
    logic [31:0] acc_val;
    logic [2:0]  bc_inc;

    phase_next       = phase;
    command_next     = command;
    address_next     = address;
    length_next      = length;
    byte_count_next  = byte_count;
    access_size_next = access_size;
    value_next       = value;
    bundle           = '0;

    sz       = size_ok(access_size) ? access_size[2:0] : 3'd1;
    ack_ok   = (command & CMD_HI_MASK) | ST_OK;
    addr_inc = address + 32'd1;
    len_dec  = length - 16'd1;
    len_sh   = {length[7:0], rx_byte};
    acc_addr = native_acc(nbe, address, rx_byte, byte_count[1:0]);
    acc_val  = native_acc(nbe, value, rx_byte, byte_count[1:0]);
    bc_inc   = byte_count + 3'd1;

    if (in_kind == IN_RDATA) begin
      if (phase == PH_RD_WAIT) begin
        bundle.res[0] = mk_tx(read_data[7:0]);
        address_next  = addr_inc;
        length_next   = len_dec;
        if (len_dec != 16'd0) begin
          bundle.res[1] = mk_bus(KIND_RD, addr_inc, 32'h0, 3'd1);
        end else begin
          bundle.res[1] = mk_tx(ack_ok);
          phase_next    = PH_IDLE;
        end
        bundle.cnt = 3'd2;
      end else if (phase == PH_V_WAIT) begin
        // Bytes of the returned value go out in native order, then the acknowledge.
        for (int i = 0; i < MAX_RES; i++) begin
          if (3'(i) < sz) begin
            bundle.res[i] = mk_tx(byte_of(read_data,
                                          nbe ? 2'(sz - 3'd1 - 3'(i)) : 2'(i)));
          end else if (3'(i) == sz) begin
            bundle.res[i] = mk_tx(ack_ok);
          end
        end
        bundle.cnt = sz + 3'd1;
        phase_next = PH_IDLE;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          command_next    = rx_byte;
          byte_count_next = '0;
          address_next    = '0;
          length_next     = '0;
          value_next      = '0;
          if (rx_byte == OP_PING) begin
            bundle.res[0] = mk_tx((rx_byte & CMD_HI_MASK) | ST_OK);
            bundle.cnt    = 3'd1;
          end else if (rx_byte == OP_READ || rx_byte == OP_WRITE) begin
            phase_next = PH_ARGS_B;
          end else if (rx_byte == OP_READV || rx_byte == OP_WRITEV) begin
            phase_next = PH_ARGS_V;
          end else if (rx_byte == OP_EXEC) begin
            phase_next = PH_ARGS_X;
          end else begin
            bundle.res[0] = mk_tx((rx_byte & CMD_HI_MASK) | ST_UNK);
            bundle.cnt    = 3'd1;
          end
        end
        PH_ARGS_B: begin
          // Four address bytes, two unused bytes, then two length bytes.
          if (byte_count < 3'd4) begin
            address_next = {address[23:0], rx_byte};
          end else if (byte_count >= 3'd6) begin
            length_next = len_sh;
          end
          if (byte_count == 3'd7) begin
            byte_count_next = '0;
            if (command == OP_READ) begin
              phase_next = PH_CK_R;
            end else begin
              phase_next = (len_sh != 16'd0) ? PH_WR_DATA : PH_CK_W;
            end
          end else begin
            byte_count_next = bc_inc;
          end
        end
        PH_CK_R: begin
          if (length != 16'd0) begin
            bundle.res[0] = mk_bus(KIND_RD, address, 32'h0, 3'd1);
            phase_next    = PH_RD_WAIT;
          end else begin
            bundle.res[0] = mk_tx(ack_ok);
            phase_next    = PH_IDLE;
          end
          bundle.cnt = 3'd1;
        end
        PH_WR_DATA: begin
          bundle.res[0] = mk_bus(KIND_WR, address, {24'h0, rx_byte}, 3'd1);
          bundle.cnt    = 3'd1;
          address_next  = addr_inc;
          length_next   = len_dec;
          if (len_dec == 16'd0) begin
            phase_next = PH_CK_W;
          end
        end
        PH_CK_W: begin
          bundle.res[0] = mk_tx(ack_ok);
          bundle.cnt    = 3'd1;
          phase_next    = PH_IDLE;
        end
        PH_ARGS_V: begin
          if (byte_count < 3'd4) begin
            address_next    = acc_addr;
            byte_count_next = bc_inc;
          end else begin
            access_size_next = rx_byte;
            byte_count_next  = '0;
            value_next       = '0;
            bundle.cnt       = 3'd1;
            if (!size_ok(rx_byte)) begin
              bundle.res[0] = mk_tx(ack_ok);
              phase_next    = PH_IDLE;
            end else if (command == OP_READV) begin
              bundle.res[0] = mk_bus(KIND_RD, address, 32'h0, rx_byte[2:0]);
              phase_next    = PH_V_WAIT;
            end else begin
              bundle.cnt = 3'd0;
              phase_next = PH_V_DATA;
            end
          end
        end
        PH_V_DATA: begin
          value_next      = acc_val;
          byte_count_next = bc_inc;
          if (!size_ok(access_size) || {5'h0, bc_inc} >= access_size) begin
            bundle.res[0]   = mk_bus(KIND_WR, address, acc_val, access_size[2:0]);
            bundle.res[1]   = mk_tx(ack_ok);
            bundle.cnt      = 3'd2;
            byte_count_next = '0;
            phase_next      = PH_IDLE;
          end
        end
        PH_ARGS_X: begin
          address_next    = acc_addr;
          byte_count_next = bc_inc;
          if (bc_inc >= 3'd4) begin
            byte_count_next = '0;
            bundle.res[0]   = mk_bus(KIND_JMP, acc_addr, 32'h0, 3'd0);
            bundle.cnt      = 3'd1;
            phase_next      = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/smm_outq.sv
`default_nettype none

module smm_outq
  import smm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire bundle_t     bundle_in,
  output logic             free,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,  // tx_byte, bus_addr, bus_wdata, bus_size, zero pad
  output logic [1:0]       m_axis_tuser,  // out_kind
  output logic             m_axis_tlast
);

  `include "serial_memory_monitor_assert.svh"

  logic       buf_valid;
  bundle_t    bnd;
  logic [2:0] idx;
  logic       last_out;
  result_t    cur;

  assign last_out = (idx == bnd.cnt - 3'd1);
  assign free     = !buf_valid || (m_axis_tready && last_out);
  assign cur      = bnd.res[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      idx       <= '0;
    end else if (free) begin
      buf_valid <= load;
      idx       <= '0;
    end else if (m_axis_tready) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      bnd <= bundle_in;
    end
  end

  assign m_axis_tvalid = buf_valid;
  assign m_axis_tdata  = {5'h0, cur.size, cur.wdata, cur.addr, cur.tx};
  assign m_axis_tuser  = cur.kind;
  assign m_axis_tlast  = last_out;

  `SMM_ASSERT_NOW(a_no_empty_bundle, buf_valid, bnd.cnt != 3'd0, "empty bundle held")
  `SMM_ASSERT_NOW(a_idx_in_range, buf_valid, idx < bnd.cnt, "result index past count")
  `SMM_ASSERT_NEXT(a_stall_holds_idx, buf_valid && !m_axis_tready,
                   buf_valid && idx == $past(idx), "stalled word lost its place")

endmodule

`default_nettype wire

// File: design/serial_memory_monitor.sv
// Channel   Dir  tdata (low bit up)                      tuser     tlast
// s_axis    in   rx_byte, read_data                      in_kind   -
// m_axis    out  tx_byte, bus_addr, bus_wdata, bus_size  out_kind  last
// cfg       in   cfg_wdata = native_big_endian, written when cfg_wen is high
//
// A word is held in the input register, decoded combinationally into all of
// its results, which leave the output register at one per cycle while
// m_axis_tready is high. A word with n results (1 to 5) holds the output
// side until its last is taken; one with none loads nothing. Its first result
// is offered from the output register. rst is synchronous, returns the decoder
// to idle and clears native_big_endian. Either side may stall at any time.
`default_nettype none

module serial_memory_monitor
  import smm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic        cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // rx_byte, read_data
  input  wire logic [0:0]  s_axis_tuser,   // in_kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // tx_byte, bus_addr, bus_wdata, bus_size, pad
  output logic [1:0]       m_axis_tuser,   // out_kind
  output logic             m_axis_tlast
);

  logic        in_valid;
  logic        in_kind;
  logic [7:0]  in_rx;
  logic [31:0] in_rd;
  logic        free;
  logic        fire;
  logic        load;
  bundle_t     bundle;

  assign fire          = in_valid && free;
  assign load          = fire && (bundle.cnt != 3'd0);
  assign s_axis_tready = !in_valid || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind <= s_axis_tuser[0];
      in_rx   <= s_axis_tdata[7:0];
      in_rd   <= s_axis_tdata[39:8];
    end
  end

  smm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .in_kind   (in_kind),
    .rx_byte   (in_rx),
    .read_data (in_rd),
    .bundle    (bundle)
  );

  smm_outq u_outq (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .bundle_in     (bundle),
    .free          (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
